// File: hdl/cnis_pkg.sv
// Package for the curve-number infiltration step: item types, register
// indexes, sequencer states and datapath widths.
// Used by every module in hdl; depends on nothing.
`timescale 1ns / 1ps

package cnis_pkg;

  // Field widths fixed by the item formats.
  localparam int unsigned DEPTH_W  = 24;
  localparam int unsigned SECS_W   = 17;
  localparam int unsigned INFIL_W  = 25;
  localparam int unsigned RET_W    = 23;
  localparam int unsigned TOTAL_W  = 32;
  localparam int unsigned RATE_W   = 24;
  localparam int unsigned POND_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Shared multiplier operands and product.
  localparam int unsigned MUL_A_W = 32;
  localparam int unsigned MUL_B_W = 24;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // Divider: dividend P*Se, divisor P+Se, quotient below Se.
  localparam int unsigned DIVIDEND_W = TOTAL_W + RET_W;
  localparam int unsigned DIVISOR_W  = TOTAL_W + 1;
  localparam int unsigned QUOT_W     = RET_W;
  localparam int unsigned DIV_STEPS  = QUOT_W;
  localparam int unsigned DIV_CNT_W  = 5;

  // Fraction bits of the regeneration rate.
  localparam int unsigned RATE_FRAC_W = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SMAX      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGEN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REGEN_EN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TMAX      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_POND  = 3'd4;

  // Reset values of the registers and state, and the saturation value of the totals.
  localparam logic [RET_W-1:0]   SMAX_RESET     = 23'd1000000;
  localparam logic [TOTAL_W-1:0] TMAX_RESET     = 32'hFFFF_FFFF;
  localparam logic [POND_W-1:0]  MIN_POND_RESET = 16'd4167;
  localparam logic [TOTAL_W-1:0] TOTAL_SAT      = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [DEPTH_W-1:0] precip_depth;
    logic [DEPTH_W-1:0] ponded_depth;
    logic [SECS_W-1:0]  step_seconds;
  } in_item_t;

  typedef struct packed {
    logic [INFIL_W-1:0] infil_depth;
    logic [RET_W-1:0]   retention_now;
    logic               new_event;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL_P,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_POT,
    ST_MUL_G,
    ST_UPDATE,
    ST_DONE
  } state_t;

endpackage

// File: hdl/cnis_mult.sv
// Shared registered multiplier of the infiltration step.
// Used for both the event product and the regeneration gain; needs cnis_pkg.
`timescale 1ns / 1ps

module cnis_mult (
  input  logic                        clk,
  input  logic [cnis_pkg::MUL_A_W-1:0] a,
  input  logic [cnis_pkg::MUL_B_W-1:0] b,
  output logic [cnis_pkg::MUL_P_W-1:0] p
);

  // One product per cycle, registered before use.
  always_ff @(posedge clk) begin
    p <= {{cnis_pkg::MUL_B_W{1'b0}}, a} * {{cnis_pkg::MUL_A_W{1'b0}}, b};
  end

endmodule

// File: hdl/cnis_div.sv
// Restoring divider for the potential infiltration P*Se/(P+Se).
// Produces one quotient bit per cycle; needs cnis_pkg.
`timescale 1ns / 1ps

module cnis_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [cnis_pkg::DIVIDEND_W-1:0]  dividend,
  input  logic [cnis_pkg::DIVISOR_W-1:0]   divisor,
  output logic                             busy,
  output logic [cnis_pkg::QUOT_W-1:0]      quotient
);

  logic [cnis_pkg::DIVISOR_W-1:0] rem;
  logic [cnis_pkg::DIVISOR_W-1:0] dvs;
  logic [cnis_pkg::QUOT_W-1:0]    quo;
  logic [cnis_pkg::DIV_CNT_W-1:0] count;
  logic [cnis_pkg::DIVISOR_W+1:0] diff;
  logic                           borrow;

  // Trial subtraction of the divisor from the shifted partial remainder.
  always_comb begin
    diff   = {1'b0, rem, quo[cnis_pkg::QUOT_W-1]} - {2'b00, dvs};
    borrow = diff[cnis_pkg::DIVISOR_W+1];
  end

  // Control: the step counter and busy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= '0;
    end else if (busy) begin
      count <= count + 1'b1;
      if (count == cnis_pkg::DIV_CNT_W'(cnis_pkg::DIV_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath: the quotient is known to fit, so the upper dividend bits
  // already form a remainder below the divisor.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {1'b0, dividend[cnis_pkg::DIVIDEND_W-1:cnis_pkg::QUOT_W]};
      quo <= dividend[cnis_pkg::QUOT_W-1:0];
      dvs <= divisor;
    end else if (busy) begin
      if (!borrow) begin
        rem <= diff[cnis_pkg::DIVISOR_W-1:0];
      end else begin
        rem <= {rem[cnis_pkg::DIVISOR_W-2:0], quo[cnis_pkg::QUOT_W-1]};
      end
      quo <= {quo[cnis_pkg::QUOT_W-2:0], ~borrow};
    end
  end

  assign quotient = quo;

endmodule

// File: hdl/curve_number_infiltration_step.sv
// Curve-number infiltration, one item per time step of one catchment. An item
// with rain passes through the radix-2 divider that forms P*Se/(P+Se) at one
// quotient bit per cycle (23 steps) and the sequencer states around it; an
// item without rain skips the divider. The input side is ready only while the
// sequencer is idle; a finished result sits in an output register and the next
// item may be taken while it waits. Registers are written through a plain
// write port while the block is idle, a rule for the user that the block itself
// does not enforce; writing smax also reloads the retention state.
// Depends on cnis_pkg, cnis_mult and cnis_div.
`timescale 1ns / 1ps

module curve_number_infiltration_step (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write_en,
  input  logic [cnis_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cnis_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  cnis_pkg::in_item_t                   in_item,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output cnis_pkg::out_item_t                  out_item
);

  // Configuration registers.
  logic [cnis_pkg::RET_W-1:0]   smax;
  logic [cnis_pkg::RATE_W-1:0]  regen_rate;
  logic                         regen_enable;
  logic [cnis_pkg::TOTAL_W-1:0] tmax_seconds;
  logic [cnis_pkg::POND_W-1:0]  min_pond_depth;

  // Catchment state.
  logic [cnis_pkg::RET_W-1:0]   retention;
  logic [cnis_pkg::RET_W-1:0]   event_retention;
  logic [cnis_pkg::TOTAL_W-1:0] precip_total;
  logic [cnis_pkg::TOTAL_W-1:0] infil_total;
  logic [cnis_pkg::INFIL_W-1:0] last_infil;
  logic [cnis_pkg::TOTAL_W-1:0] dry_time;

  // Per-item working registers.
  cnis_pkg::state_t             state, state_next;
  cnis_pkg::in_item_t           item;
  logic [cnis_pkg::INFIL_W-1:0] f1;
  logic                         new_event;

  // Shared unit connections.
  logic [cnis_pkg::MUL_A_W-1:0]    mul_a;
  logic [cnis_pkg::MUL_B_W-1:0]    mul_b;
  logic [cnis_pkg::MUL_P_W-1:0]    mul_p;
  logic                            div_start;
  logic                            div_busy;
  logic [cnis_pkg::DIVISOR_W-1:0]  div_den;
  logic [cnis_pkg::QUOT_W-1:0]     div_quo;

  // Step arithmetic.
  logic                           rain;
  logic                           ev_start;
  logic [cnis_pkg::TOTAL_W-1:0]   ptot_base;
  logic [cnis_pkg::TOTAL_W:0]     ptot_sum;
  logic [cnis_pkg::TOTAL_W:0]     dry_sum;
  logic [cnis_pkg::INFIL_W-1:0]   ret_ext;
  logic [cnis_pkg::INFIL_W-1:0]   avail;
  logic [cnis_pkg::INFIL_W-1:0]   f1_cap;
  logic [cnis_pkg::TOTAL_W:0]     infil_sum;
  logic [cnis_pkg::INFIL_W-1:0]   gain;
  logic [cnis_pkg::INFIL_W:0]     regen_sum;
  logic                           out_load;

  assign rain      = item.precip_depth != '0;
  assign ev_start  = dry_time >= tmax_seconds;
  assign ptot_base = ev_start ? '0 : precip_total;
  assign ptot_sum  = {1'b0, ptot_base} + (cnis_pkg::TOTAL_W + 1)'(item.precip_depth);
  assign dry_sum   = {1'b0, dry_time} + (cnis_pkg::TOTAL_W + 1)'(item.step_seconds);
  assign ret_ext   = cnis_pkg::INFIL_W'(retention);
  assign avail     = {1'b0, item.precip_depth} + {1'b0, item.ponded_depth};
  assign f1_cap    = (f1 > avail) ? avail : f1;
  assign infil_sum = {1'b0, infil_total} + (cnis_pkg::TOTAL_W + 1)'(f1_cap);
  assign gain      = mul_p[cnis_pkg::RATE_FRAC_W +: cnis_pkg::INFIL_W];
  assign regen_sum = (cnis_pkg::INFIL_W + 1)'(retention) + {1'b0, gain};
  assign div_den   = {1'b0, precip_total} + cnis_pkg::DIVISOR_W'(event_retention);
  assign div_start = (state == cnis_pkg::ST_DIV_START);
  assign out_load  = (state == cnis_pkg::ST_DONE) && (!out_valid || out_ready);
  assign in_ready  = (state == cnis_pkg::ST_IDLE);

  // Multiplier operands: the event product, otherwise the regeneration gain.
  always_comb begin
    if (state == cnis_pkg::ST_MUL_P) begin
      mul_a = precip_total;
      mul_b = cnis_pkg::MUL_B_W'(event_retention);
    end else begin
      mul_a = cnis_pkg::MUL_A_W'(item.step_seconds);
      mul_b = regen_rate;
    end
  end

  cnis_mult u_mult (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  cnis_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mul_p[cnis_pkg::DIVIDEND_W-1:0]),
    .divisor  (div_den),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cnis_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      cnis_pkg::ST_IDLE: begin
        if (in_valid) state_next = cnis_pkg::ST_PREP;
      end
      cnis_pkg::ST_PREP: begin
        state_next = rain ? cnis_pkg::ST_MUL_P : cnis_pkg::ST_MUL_G;
      end
      cnis_pkg::ST_MUL_P:     state_next = cnis_pkg::ST_DIV_START;
      cnis_pkg::ST_DIV_START: state_next = cnis_pkg::ST_DIV_WAIT;
      cnis_pkg::ST_DIV_WAIT: begin
        if (!div_busy) state_next = cnis_pkg::ST_POT;
      end
      cnis_pkg::ST_POT:    state_next = cnis_pkg::ST_MUL_G;
      cnis_pkg::ST_MUL_G:  state_next = cnis_pkg::ST_UPDATE;
      cnis_pkg::ST_UPDATE: state_next = cnis_pkg::ST_DONE;
      cnis_pkg::ST_DONE: begin
        if (!out_valid || out_ready) state_next = cnis_pkg::ST_IDLE;
      end
      default: state_next = cnis_pkg::ST_IDLE;
    endcase
  end

  // Input item capture.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

  // Configuration registers and catchment state.
  always_ff @(posedge clk) begin
    if (rst) begin
      smax            <= cnis_pkg::SMAX_RESET;
      regen_rate      <= '0;
      regen_enable    <= 1'b0;
      tmax_seconds    <= cnis_pkg::TMAX_RESET;
      min_pond_depth  <= cnis_pkg::MIN_POND_RESET;
      retention       <= cnis_pkg::SMAX_RESET;
      event_retention <= cnis_pkg::SMAX_RESET;
      precip_total    <= '0;
      infil_total     <= '0;
      last_infil      <= '0;
      dry_time        <= '0;
      new_event       <= 1'b0;
      f1              <= '0;
    end else begin
      // Register writes must arrive only while idle; the block itself does not enforce this.
      if (cfg_write_en) begin
        unique case (cfg_index)
          cnis_pkg::REG_SMAX: begin
            smax            <= cfg_data[cnis_pkg::RET_W-1:0];
            retention       <= cfg_data[cnis_pkg::RET_W-1:0];
            event_retention <= cfg_data[cnis_pkg::RET_W-1:0];
          end
          cnis_pkg::REG_REGEN:    regen_rate     <= cfg_data[cnis_pkg::RATE_W-1:0];
          cnis_pkg::REG_REGEN_EN: regen_enable   <= cfg_data[0];
          cnis_pkg::REG_TMAX:     tmax_seconds   <= cfg_data;
          cnis_pkg::REG_MIN_POND: min_pond_depth <= cfg_data[cnis_pkg::POND_W-1:0];
          default: ;
        endcase
      end

      case (state)
        // Event bookkeeping, dry time and the ponding carry-over.
        cnis_pkg::ST_PREP: begin
          if (rain) begin
            f1        <= '0;
            new_event <= ev_start;
            if (ev_start) begin
              infil_total     <= '0;
              last_infil      <= '0;
              event_retention <= retention;
            end
            dry_time     <= '0;
            precip_total <= ptot_sum[cnis_pkg::TOTAL_W] ? cnis_pkg::TOTAL_SAT
                                                        : ptot_sum[cnis_pkg::TOTAL_W-1:0];
          end else begin
            new_event <= 1'b0;
            if (item.ponded_depth > cnis_pkg::DEPTH_W'(min_pond_depth) &&
                retention != '0) begin
              f1 <= (last_infil > ret_ext) ? ret_ext : last_infil;
            end else begin
              f1       <= '0;
              dry_time <= dry_sum[cnis_pkg::TOTAL_W] ? cnis_pkg::TOTAL_SAT
                                                     : dry_sum[cnis_pkg::TOTAL_W-1:0];
            end
          end
        end

        // Increment over what this event has already infiltrated.
        cnis_pkg::ST_POT: begin
          if (cnis_pkg::TOTAL_W'(div_quo) > infil_total && retention != '0) begin
            f1 <= cnis_pkg::INFIL_W'(div_quo - infil_total[cnis_pkg::QUOT_W-1:0]);
          end
        end

        // Cap at the available water, then deplete or regenerate retention.
        cnis_pkg::ST_UPDATE: begin
          if (f1 != '0) begin
            infil_total <= infil_sum[cnis_pkg::TOTAL_W] ? cnis_pkg::TOTAL_SAT
                                                        : infil_sum[cnis_pkg::TOTAL_W-1:0];
            if (regen_enable) begin
              retention <= (f1_cap >= ret_ext) ? '0
                         : retention - f1_cap[cnis_pkg::RET_W-1:0];
            end
          end else if (regen_enable) begin
            retention <= (regen_sum > (cnis_pkg::INFIL_W + 1)'(smax)) ? smax
                       : regen_sum[cnis_pkg::RET_W-1:0];
          end
          last_infil <= f1_cap;
        end

        default: ;
      endcase
    end
  end

  // Output register: holds a result until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item.infil_depth   <= last_infil;
      out_item.retention_now <= retention;
      out_item.new_event     <= new_event;
    end
  end

endmodule

// File: tb/sv/tb_curve_number_infiltration_step.sv
// Self-checking testbench for the curve-number infiltration step.
// A queue-fed driver and a clocked monitor run against a bit-exact predictor;
// depends on cnis_pkg and the curve_number_infiltration_step RTL.
`timescale 1ns / 1ps

module tb_curve_number_infiltration_step;

  localparam int unsigned CYCLE_LIMIT     = 400_000;
  localparam int unsigned ITEMS_PER_PHASE = 90;
  localparam int unsigned RANDOM_PHASES   = 6;
  localparam int unsigned LONG_HOLD       = 400;
  localparam int unsigned SAT_RAIN_STEPS  = 280;
  localparam int unsigned SAT_POND_STEPS  = 20;
  localparam logic [cnis_pkg::CFG_IDX_W-1:0] REG_LAST_INDEX = 3'd7;
  localparam logic [cnis_pkg::RET_W-1:0]     SMAX_TOP  = 23'h7F_FFFF;
  localparam logic [cnis_pkg::DEPTH_W-1:0]   DEPTH_TOP = 24'hFF_FFFF;
  localparam logic [cnis_pkg::SECS_W-1:0]    SECS_TOP  = 17'h1_FFFF;

  typedef enum int {STEP_RAIN, STEP_POND, STEP_DRY, STEP_LONG_DRY, STEP_NOISE} step_kind_t;
  typedef enum int {RX_ALWAYS, RX_HALF, RX_MOSTLY, RX_SPARSE} rx_mode_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_write_en = 1'b0;
  logic [cnis_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [cnis_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  cnis_pkg::in_item_t              in_item = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  cnis_pkg::out_item_t             out_item;

  // Predictor copy of the registers.
  logic [cnis_pkg::RET_W-1:0]   cfg_smax;
  logic [cnis_pkg::RATE_W-1:0]  cfg_rate;
  logic                         cfg_regen_on;
  logic [cnis_pkg::TOTAL_W-1:0] cfg_tmax;
  logic [cnis_pkg::POND_W-1:0]  cfg_min_pond;

  // Predictor copy of the catchment state.
  logic [cnis_pkg::RET_W-1:0]   ret_left;
  logic [cnis_pkg::RET_W-1:0]   event_ret;
  logic [cnis_pkg::TOTAL_W-1:0] rain_total;
  logic [cnis_pkg::TOTAL_W-1:0] infil_sum;
  logic [cnis_pkg::INFIL_W-1:0] prev_infil;
  logic [cnis_pkg::TOTAL_W-1:0] dry_secs;

  cnis_pkg::in_item_t  step_backlog[$];
  cnis_pkg::out_item_t predicted_steps[$];

  int unsigned items_taken = 0;
  int unsigned results_checked = 0;
  int unsigned rain_steps = 0;
  int unsigned new_events_seen = 0;
  int unsigned mismatches = 0;
  int unsigned settings_used = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_requests = 0;
  bit          fast_mode = 1'b0;

  curve_number_infiltration_step u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_item     (out_item)
  );

  always #5 clk = ~clk;

  // Run limit in clock cycles.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               predicted_steps.size());
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [cnis_pkg::TOTAL_W-1:0] add_clamped(
      input logic [cnis_pkg::TOTAL_W-1:0] a, input logic [cnis_pkg::TOTAL_W-1:0] b);
    logic [cnis_pkg::TOTAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[cnis_pkg::TOTAL_W] ? cnis_pkg::TOTAL_SAT : s[cnis_pkg::TOTAL_W-1:0];
  endfunction

  // Advances the predicted catchment state by one step and returns its result.
  function automatic cnis_pkg::out_item_t step_infiltration(input cnis_pkg::in_item_t it);
    logic [63:0] prec, pond, secs, avail, f1, p64, s64, num, den, pot, gain, sum;
    cnis_pkg::out_item_t res;
    prec = 64'(it.precip_depth);
    pond = 64'(it.ponded_depth);
    secs = 64'(it.step_seconds);
    avail = prec + pond;
    f1 = '0;
    res.new_event = 1'b0;
    if (prec != 64'd0) begin
      // Rain after a long enough dry spell opens a new event.
      if (dry_secs >= cfg_tmax) begin
        rain_total = '0;
        infil_sum = '0;
        prev_infil = '0;
        event_ret = ret_left;
        res.new_event = 1'b1;
      end
      dry_secs = '0;
      rain_total = add_clamped(rain_total, cnis_pkg::TOTAL_W'(it.precip_depth));
      p64 = 64'(rain_total);
      s64 = 64'(event_ret);
      num = p64 * s64;
      den = p64 + s64;
      pot = (den != 64'd0) ? num / den : 64'd0;
      if (pot > 64'(infil_sum) && ret_left != '0) f1 = pot - 64'(infil_sum);
    end else if (it.ponded_depth > cnis_pkg::DEPTH_W'(cfg_min_pond) && ret_left != '0) begin
      // Ponded water keeps soaking in at the previous rate.
      f1 = 64'(prev_infil);
      if (f1 > 64'(ret_left)) f1 = 64'(ret_left);
    end else begin
      dry_secs = add_clamped(dry_secs, cnis_pkg::TOTAL_W'(it.step_seconds));
    end

    if (f1 != 64'd0) begin
      if (f1 > avail) f1 = avail;
      infil_sum = add_clamped(infil_sum, f1[cnis_pkg::TOTAL_W-1:0]);
      if (cfg_regen_on)
        ret_left = (f1 >= 64'(ret_left)) ? '0 : ret_left - f1[cnis_pkg::RET_W-1:0];
    end else if (cfg_regen_on) begin
      gain = (64'(cfg_rate) * secs) >> cnis_pkg::RATE_FRAC_W;
      sum = 64'(ret_left) + gain;
      if (sum > 64'(cfg_smax)) sum = 64'(cfg_smax);
      ret_left = sum[cnis_pkg::RET_W-1:0];
    end

    prev_infil = f1[cnis_pkg::INFIL_W-1:0];
    res.infil_depth = f1[cnis_pkg::INFIL_W-1:0];
    res.retention_now = ret_left;
    return res;
  endfunction

  // Random step of a given kind; ranges follow the current settings.
  function automatic cnis_pkg::in_item_t make_step(input step_kind_t kind);
    cnis_pkg::in_item_t it;
    int unsigned pick;
    int unsigned secs_val;
    int unsigned pond_floor;
    pond_floor = {16'd0, cfg_min_pond};
    pick = $urandom_range(0, 15);
    if (pick == 0) secs_val = 0;
    else if (pick == 1) secs_val = $urandom_range(0, 131071);
    else secs_val = $urandom_range(1, 86400);
    it.step_seconds = cnis_pkg::SECS_W'(secs_val);
    it.precip_depth = '0;
    it.ponded_depth = '0;
    pick = $urandom_range(0, 7);
    case (kind)
      STEP_RAIN: begin
        if (pick < 4) it.precip_depth = cnis_pkg::DEPTH_W'($urandom_range(1, 50000));
        else if (pick < 6) it.precip_depth = cnis_pkg::DEPTH_W'($urandom_range(1, 16777215));
        else if (pick == 6) it.precip_depth = cnis_pkg::DEPTH_W'($urandom_range(1, 16));
        else it.precip_depth = DEPTH_TOP;
        if ($urandom_range(0, 1) == 1)
          it.ponded_depth = cnis_pkg::DEPTH_W'($urandom_range(0, 16777215));
      end
      STEP_POND: begin
        if (pick == 0) it.ponded_depth = DEPTH_TOP;
        else it.ponded_depth = cnis_pkg::DEPTH_W'(pond_floor + $urandom_range(1, 1000000));
      end
      STEP_DRY: begin
        it.ponded_depth = cnis_pkg::DEPTH_W'($urandom_range(0, pond_floor));
      end
      STEP_LONG_DRY: begin
        it.step_seconds = cnis_pkg::SECS_W'($urandom_range(40000, 131071));
      end
      default: begin
        if (pick < 4) it.precip_depth = cnis_pkg::DEPTH_W'($urandom);
        it.ponded_depth = cnis_pkg::DEPTH_W'($urandom);
        it.step_seconds = cnis_pkg::SECS_W'($urandom_range(0, 131071));
      end
    endcase
    return it;
  endfunction

  // Register write on the falling edge; the predictor follows at once since
  // writes only happen while the block is idle.
  task automatic write_register(input logic [cnis_pkg::CFG_IDX_W-1:0] idx,
                                input logic [cnis_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    case (idx)
      cnis_pkg::REG_SMAX: begin
        cfg_smax  = data[cnis_pkg::RET_W-1:0];
        ret_left  = data[cnis_pkg::RET_W-1:0];
        event_ret = data[cnis_pkg::RET_W-1:0];
      end
      cnis_pkg::REG_REGEN:    cfg_rate = data[cnis_pkg::RATE_W-1:0];
      cnis_pkg::REG_REGEN_EN: cfg_regen_on = data[0];
      cnis_pkg::REG_TMAX:     cfg_tmax = data;
      cnis_pkg::REG_MIN_POND: cfg_min_pond = data[cnis_pkg::POND_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic write_all(input logic [cnis_pkg::RET_W-1:0] smax_v,
                           input logic [cnis_pkg::RATE_W-1:0] rate_v,
                           input logic en_v,
                           input logic [cnis_pkg::TOTAL_W-1:0] tmax_v,
                           input logic [cnis_pkg::POND_W-1:0] pond_v);
    logic [31:0] junk;
    junk = $urandom;
    // Unused upper data bits carry noise; the block must ignore them.
    write_register(cnis_pkg::REG_SMAX, {junk[31:23], smax_v});
    write_register(cnis_pkg::REG_REGEN, {junk[7:0], rate_v});
    write_register(cnis_pkg::REG_REGEN_EN, {junk[30:0], en_v});
    write_register(cnis_pkg::REG_TMAX, tmax_v);
    write_register(cnis_pkg::REG_MIN_POND, {junk[15:0], pond_v});
    settings_used++;
    @(posedge clk);
  endtask

  task automatic push_step(input logic [cnis_pkg::DEPTH_W-1:0] p,
                           input logic [cnis_pkg::DEPTH_W-1:0] d,
                           input logic [cnis_pkg::SECS_W-1:0] s);
    cnis_pkg::in_item_t it;
    it.precip_depth = p;
    it.ponded_depth = d;
    it.step_seconds = s;
    step_backlog.push_back(it);
  endtask

  // Waits until every queued step is taken and answered, plus a short margin.
  task automatic drain;
    while (step_backlog.size() != 0 || in_valid || predicted_steps.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Driver: bursts of items with random gaps, valid held until accepted.
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && items_taken != items_sent) begin
      // Hold the offered item.
    end else if (gap_left > 0 && !fast_mode) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (step_backlog.size() > 0) begin
      in_item  <= step_backlog.pop_front();
      in_valid <= 1'b1;
      items_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: stall pattern that changes now and then, plus long hold-offs.
  int unsigned stall_served = 0;
  int unsigned hold_left = 0;
  int unsigned mode_left = 0;
  rx_mode_t    rx_mode = RX_ALWAYS;
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_served != stall_requests) begin
      stall_served++;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (fast_mode) begin
      out_ready <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      case (rx_mode)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_HALF:   out_ready <= ($urandom_range(0, 1) == 1);
        RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
        default:   out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Monitor: predicts on each accepted step and checks each accepted result.
  always @(posedge clk) begin : monitor
    cnis_pkg::out_item_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        predicted_steps.push_back(step_infiltration(in_item));
        items_taken++;
        if (in_item.precip_depth != '0) rain_steps++;
      end
      if (out_valid && out_ready) begin
        results_checked++;
        if (out_item.new_event) new_events_seen++;
        if (predicted_steps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result %0d arrived with nothing expected: infil=%0d ret=%0d event=%0d",
                     results_checked, out_item.infil_depth, out_item.retention_now,
                     out_item.new_event);
        end else begin
          want = predicted_steps.pop_front();
          if (want.infil_depth !== out_item.infil_depth ||
              want.retention_now !== out_item.retention_now ||
              want.new_event !== out_item.new_event) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"Result %0d mismatch: expected infil=%0d ret=%0d event=%0d,",
                        " got infil=%0d ret=%0d event=%0d"},
                       results_checked, want.infil_depth, want.retention_now,
                       want.new_event, out_item.infil_depth, out_item.retention_now,
                       out_item.new_event);
          end
        end
      end
    end
  end

  // Stimulus sequencer.
  initial begin : stimulus
    int unsigned n, k, m, d, pick;
    logic [cnis_pkg::RET_W-1:0]   smax_v;
    logic [cnis_pkg::RATE_W-1:0]  rate_v;
    logic [cnis_pkg::TOTAL_W-1:0] tmax_v;
    logic [cnis_pkg::POND_W-1:0]  pond_v;

    cfg_smax     = cnis_pkg::SMAX_RESET;
    cfg_rate     = '0;
    cfg_regen_on = 1'b0;
    cfg_tmax     = cnis_pkg::TMAX_RESET;
    cfg_min_pond = cnis_pkg::MIN_POND_RESET;
    ret_left     = cnis_pkg::SMAX_RESET;
    event_ret    = cnis_pkg::SMAX_RESET;
    rain_total   = '0;
    infil_sum    = '0;
    prev_infil   = '0;
    dry_secs     = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: field extremes, ponding at and just above the threshold.
    push_step('0, '0, '0);
    push_step(DEPTH_TOP, DEPTH_TOP, 17'd1);
    push_step('0, 24'd4168, 17'd60);
    push_step('0, 24'd4167, 17'd60);
    push_step(24'd1, '0, 17'd86400);
    push_step('0, DEPTH_TOP, SECS_TOP);
    push_step('0, '0, 17'd86400);
    drain;

    // Small retention with fast recovery and every rain a new event:
    // depletion to zero, rain on empty retention, capped recovery, zero length.
    write_all(23'd2000, {cnis_pkg::RATE_W{1'b1}}, 1'b1, '0, '0);
    push_step(24'd500, '0, 17'd10);
    push_step(DEPTH_TOP, '0, 17'd1);
    push_step(24'd5000, '0, 17'd1);
    push_step(24'd5000, '0, 17'd1);
    push_step(24'd100, '0, 17'd1);
    push_step('0, '0, 17'd100);
    push_step('0, '0, '0);
    push_step('0, 24'd1, 17'd5);
    drain;

    // Slow recovery where the fraction of a unit is dropped.
    write_all(23'd3000, 24'd100, 1'b1, 32'd1000, 16'd10);
    push_step(24'd2000, '0, 17'd1);
    push_step('0, '0, 17'd655);
    push_step('0, '0, 17'd656);
    push_step('0, '0, 17'd86400);
    drain;

    // Saturation run: the rain total clamps while the divider works on its
    // widest operands, then ponding carries the last depth forward.
    write_all(SMAX_TOP, '0, 1'b0, cnis_pkg::TMAX_RESET, cnis_pkg::MIN_POND_RESET);
    fast_mode = 1'b1;
    push_step(DEPTH_TOP, DEPTH_TOP, 17'd1);
    repeat (SAT_RAIN_STEPS) push_step(DEPTH_TOP, '0, 17'd1);
    repeat (SAT_POND_STEPS) push_step('0, DEPTH_TOP, 17'd1);
    drain;
    @(posedge clk);
    fast_mode = 1'b0;

    // Random phases: storms of rain, ponding and drying, plus noise.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0) begin
        write_all('0, '0, 1'b0, '0, '0);
      end else if (ph == 1) begin
        write_all(SMAX_TOP, {cnis_pkg::RATE_W{1'b1}}, 1'b1, cnis_pkg::TMAX_RESET,
                  {cnis_pkg::POND_W{1'b1}});
      end else begin
        pick = $urandom_range(0, 7);
        if (pick == 0) smax_v = '0;
        else if (pick == 1) smax_v = SMAX_TOP;
        else if (pick < 4) smax_v = cnis_pkg::RET_W'($urandom_range(1, 5000));
        else smax_v = cnis_pkg::RET_W'($urandom);
        pick = $urandom_range(0, 3);
        rate_v = (pick == 0) ? '0 : (pick == 1) ? {cnis_pkg::RATE_W{1'b1}}
                                                : cnis_pkg::RATE_W'($urandom);
        pick = $urandom_range(0, 3);
        if (pick == 0) tmax_v = '0;
        else if (pick == 1) tmax_v = $urandom;
        else tmax_v = $urandom_range(0, 500000);
        pick = $urandom_range(0, 3);
        pond_v = (pick == 0) ? '0 : (pick == 1) ? {cnis_pkg::POND_W{1'b1}}
                                                : cnis_pkg::POND_W'($urandom);
        write_all(smax_v, rate_v, ($urandom_range(0, 1) == 1), tmax_v, pond_v);
      end
      // Indexes past the last register must change nothing.
      if (ph == 3)
        for (int idx = int'(cnis_pkg::REG_MIN_POND) + 1; idx <= int'(REG_LAST_INDEX);
             idx++) begin
          write_register(cnis_pkg::CFG_IDX_W'(idx), $urandom);
        end
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 19);
        if (pick < 12) begin
          k = $urandom_range(1, 8);
          m = $urandom_range(0, 5);
          d = $urandom_range(0, 6);
          repeat (k) step_backlog.push_back(make_step(STEP_RAIN));
          repeat (m) step_backlog.push_back(make_step(STEP_POND));
          repeat (d) step_backlog.push_back(make_step(STEP_DRY));
          n += k + m + d;
        end else if (pick < 17) begin
          step_backlog.push_back(make_step(STEP_NOISE));
          n++;
        end else begin
          d = $urandom_range(3, 20);
          repeat (d) step_backlog.push_back(make_step(STEP_LONG_DRY));
          n += d;
        end
      end
      // Hold the receiver off while the sender keeps offering items.
      if (ph == 2) stall_requests++;
      drain;
    end

    repeat (40) @(posedge clk);
    $display("Checked %0d results from %0d steps (%0d with rain, %0d new events),",
             results_checked, items_taken, rain_steps, new_events_seen);
    $display("over %0d settings with a clamped rain total and %0d mismatches.",
             settings_used, mismatches);
    if (mismatches == 0 && predicted_steps.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: curve_number_infiltration_step.f
hdl/cnis_pkg.sv
hdl/cnis_mult.sv
hdl/cnis_div.sv
hdl/curve_number_infiltration_step.sv
tb/sv/tb_curve_number_infiltration_step.sv
